// File: hw/rtl/dwbw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dwbw_pkg;

  localparam int unsigned BURST_PIXELS = 20;
  localparam int unsigned BPOS_W       = $clog2(BURST_PIXELS + 1);
  localparam int unsigned START_BYTES  = 11;
  localparam int unsigned IDX_W        = $clog2(START_BYTES);
  localparam int unsigned COORD_W      = 16;
  localparam int unsigned TOTAL_W      = 24;
  localparam int unsigned PIXEL_W      = 16;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 24;

  localparam logic [7:0] CMD_COLUMN_ADDR  = 8'h2A;
  localparam logic [7:0] CMD_ROW_ADDR     = 8'h2B;
  localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_PIXEL = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_COL_START   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COL_END     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ROW_START   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_ROW_END     = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_TOTAL = CFG_IDX_W'(4);

  typedef struct packed {
    logic [COORD_W-1:0] col_start;
    logic [COORD_W-1:0] col_end;
    logic [COORD_W-1:0] row_start;
    logic [COORD_W-1:0] row_end;
  } window_t;

  // One request's worth of output work, handed from the frame control to the byte sequencer
  typedef struct packed {
    logic               start;
    logic [PIXEL_W-1:0] pixel;
    logic               burst;
    logic               final_px;
    window_t            win;
  } job_t;

endpackage

`default_nettype wire

// File: hw/rtl/dwbw_frame_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module dwbw_frame_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          accept_i,
  input  wire logic                          mode_i,
  input  wire logic [dwbw_pkg::PIXEL_W-1:0]  pixel_value_i,
  input  wire dwbw_pkg::window_t             win_i,
  input  wire logic [dwbw_pkg::TOTAL_W-1:0]  pixel_total_i,
  output logic                               load_o,
  output dwbw_pkg::job_t                     job_o
);
  import dwbw_pkg::*;

  logic               frame_open_q, frame_open_d;
  logic [TOTAL_W-1:0] sent_q, sent_d;
  logic [BPOS_W-1:0]  bpos_q, bpos_d;
  logic [TOTAL_W-1:0] sent_inc;
  logic [BPOS_W-1:0]  bpos_inc;
  logic               burst_full;
  logic               is_final;

  assign sent_inc   = sent_q + TOTAL_W'(1);
  assign bpos_inc   = bpos_q + BPOS_W'(1);
  assign burst_full = (bpos_inc >= BPOS_W'(BURST_PIXELS));
  assign is_final   = (sent_inc >= pixel_total_i);

  always_comb begin
    frame_open_d = frame_open_q;
    sent_d       = sent_q;
    bpos_d       = bpos_q;
    load_o       = 1'b0;
    if (accept_i) begin
      if (mode_i == MODE_START) begin
        // restart: an empty window leaves the frame closed
        frame_open_d = (pixel_total_i != '0);
        sent_d       = '0;
        bpos_d       = '0;
        load_o       = 1'b1;
      end else if (frame_open_q) begin
        sent_d = sent_inc;
        bpos_d = burst_full ? '0 : bpos_inc;
        if (is_final) begin
          frame_open_d = 1'b0;
        end
        load_o = 1'b1;
      end
    end
  end

  always_comb begin
    job_o.start    = (mode_i == MODE_START);
    job_o.pixel    = pixel_value_i;
    job_o.burst    = burst_full | is_final;
    job_o.final_px = is_final;
    job_o.win      = win_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q <= 1'b0;
      sent_q       <= '0;
      bpos_q       <= '0;
    end else begin
      frame_open_q <= frame_open_d;
      sent_q       <= sent_d;
      bpos_q       <= bpos_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/dwbw_byte_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module dwbw_byte_seq (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            load_i,
  input  wire dwbw_pkg::job_t  job_i,
  output logic                 ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [7:0]           out_byte_o,
  output logic                 is_command_o,
  output logic                 last_of_run_o,
  output logic                 burst_end_o,
  output logic                 frame_end_o
);
  import dwbw_pkg::*;

  logic             job_valid_q;
  job_t             job_q;
  logic [IDX_W-1:0] idx_q;
  logic             out_valid_q;
  logic [7:0]       byte_q;
  logic             cmd_q, last_q, burst_q, frame_q;

  logic             emit;
  logic             last_byte;
  logic [7:0]       byte_d;
  logic             cmd_d, burst_d, frame_d;

  assign emit      = job_valid_q && (!out_valid_q || out_ready_i);
  assign last_byte = job_q.start ? (idx_q == IDX_W'(START_BYTES - 1))
                                 : (idx_q == IDX_W'(1));
  assign ready_o   = !job_valid_q || (emit && last_byte);

  always_comb begin
    byte_d  = '0;
    cmd_d   = 1'b0;
    burst_d = 1'b0;
    frame_d = 1'b0;
    if (job_q.start) begin
      case (idx_q)
        IDX_W'(0):  begin byte_d = CMD_COLUMN_ADDR; cmd_d = 1'b1; end
        IDX_W'(1):  byte_d = job_q.win.col_start[15:8];
        IDX_W'(2):  byte_d = job_q.win.col_start[7:0];
        IDX_W'(3):  byte_d = job_q.win.col_end[15:8];
        IDX_W'(4):  byte_d = job_q.win.col_end[7:0];
        IDX_W'(5):  begin byte_d = CMD_ROW_ADDR; cmd_d = 1'b1; end
        IDX_W'(6):  byte_d = job_q.win.row_start[15:8];
        IDX_W'(7):  byte_d = job_q.win.row_start[7:0];
        IDX_W'(8):  byte_d = job_q.win.row_end[15:8];
        IDX_W'(9):  byte_d = job_q.win.row_end[7:0];
        IDX_W'(10): begin byte_d = CMD_MEMORY_WRITE; cmd_d = 1'b1; end
        default:    byte_d = '0;
      endcase
    end else if (idx_q == '0) begin
      byte_d = job_q.pixel[15:8];
    end else begin
      byte_d  = job_q.pixel[7:0];
      burst_d = job_q.burst;
      frame_d = job_q.final_px;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_i) begin
        job_valid_q <= 1'b1;
        idx_q       <= '0;
      end else if (emit && last_byte) begin
        job_valid_q <= 1'b0;
      end else if (emit) begin
        idx_q <= idx_q + IDX_W'(1);
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      job_q <= job_i;
    end
    // hold the result register while the receiver stalls
    if (emit) begin
      byte_q  <= byte_d;
      cmd_q   <= cmd_d;
      last_q  <= last_byte;
      burst_q <= burst_d;
      frame_q <= frame_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = byte_q;
  assign is_command_o  = cmd_q;
  assign last_of_run_o = last_q;
  assign burst_end_o   = burst_q;
  assign frame_end_o   = frame_q;

endmodule

`default_nettype wire

// File: hw/rtl/display_window_byte_writer_unit.sv
// Display window byte writer.
// Input channel (in_valid_i / in_ready_o): a request with mode_i low starts a
// window frame and yields eleven bytes: 0x2A with the big-endian column start
// and end, 0x2B with the row start and end, then 0x2C. A request with mode_i
// high carries one RGB565 pixel and yields two data bytes, high byte first,
// while a frame is open; outside a frame it is taken and dropped.
// Output channel (out_valid_o / out_ready_i) carries one byte per transfer
// with command, last-of-request, burst-end and frame-end flags.
// A request is registered in the byte sequencer, then its first byte moves
// to the result register when the output is free. Throughput: one byte per
// cycle out of the sequencer while the receiver does not stall; the next
// request is taken in the cycle its predecessor's last byte is registered.
// Configuration writes (cfg_we_i, cfg_index_i, cfg_data_i) take effect on
// the next edge; unknown indices are ignored.
// Reset clears all window registers, the frame state and the counters and
// empties the result register. When the receiver stalls the result byte is
// held and the sequencer stops; a new request is refused until the current
// one has moved its last byte out.
`timescale 1ns / 1ps
`default_nettype none

module display_window_byte_writer_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic                             mode_i,
  input  wire logic [dwbw_pkg::PIXEL_W-1:0]     pixel_value_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [7:0]                            out_byte_o,
  output logic                                  is_command_o,
  output logic                                  last_of_run_o,
  output logic                                  burst_end_o,
  output logic                                  frame_end_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [dwbw_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [dwbw_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import dwbw_pkg::*;

  window_t            win_q;
  logic [TOTAL_W-1:0] total_q;
  logic               accept;
  logic               load;
  job_t               job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      total_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_COL_START:   win_q.col_start <= cfg_data_i[COORD_W-1:0];
        REG_COL_END:     win_q.col_end   <= cfg_data_i[COORD_W-1:0];
        REG_ROW_START:   win_q.row_start <= cfg_data_i[COORD_W-1:0];
        REG_ROW_END:     win_q.row_end   <= cfg_data_i[COORD_W-1:0];
        REG_PIXEL_TOTAL: total_q         <= cfg_data_i[TOTAL_W-1:0];
        default:         ;
      endcase
    end
  end

  assign accept = in_valid_i && in_ready_o;

  dwbw_frame_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .mode_i        (mode_i),
    .pixel_value_i (pixel_value_i),
    .win_i         (win_q),
    .pixel_total_i (total_q),
    .load_o        (load),
    .job_o         (job)
  );

  dwbw_byte_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .job_i         (job),
    .ready_o       (in_ready_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .is_command_o  (is_command_o),
    .last_of_run_o (last_of_run_o),
    .burst_end_o   (burst_end_o),
    .frame_end_o   (frame_end_o)
  );

endmodule

`default_nettype wire

// File: test/display_window_byte_writer_unit_tb.sv
`timescale 1ns / 1ps

module display_window_byte_writer_unit_tb;
  import dwbw_pkg::*;

  typedef struct packed {
    logic [7:0] value;
    logic       cmd;
    logic       last;
    logic       burst;
    logic       frame;
  } panel_byte_t;

  // Mirrors the frame control and byte order of the unit and holds the bytes still owed.
  class panel_byte_tracker;
    logic [COORD_W-1:0] col_start, col_end, row_start, row_end;
    logic [TOTAL_W-1:0] pixel_total;
    logic               frame_open;
    logic [TOTAL_W-1:0] pixels_sent;
    logic [BPOS_W-1:0]  burst_pos;
    panel_byte_t        bytes_due[$];
    int unsigned starts, pixels_taken, pixels_dropped, frames_closed, bytes_checked, faults;

    function new();
      col_start = '0; col_end = '0; row_start = '0; row_end = '0; pixel_total = '0;
      frame_open = 1'b0; pixels_sent = '0; burst_pos = '0;
      starts = 0; pixels_taken = 0; pixels_dropped = 0;
      frames_closed = 0; bytes_checked = 0; faults = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_COL_START:   col_start = data[COORD_W-1:0];
        REG_COL_END:     col_end = data[COORD_W-1:0];
        REG_ROW_START:   row_start = data[COORD_W-1:0];
        REG_ROW_END:     row_end = data[COORD_W-1:0];
        REG_PIXEL_TOTAL: pixel_total = data[TOTAL_W-1:0];
        default: ;
      endcase
    endfunction

    function void owe(logic [7:0] v, logic c, logic l, logic b, logic f);
      panel_byte_t e;
      e.value = v; e.cmd = c; e.last = l; e.burst = b; e.frame = f;
      bytes_due.push_back(e);
    endfunction

    function void owe_word(logic [COORD_W-1:0] w);
      owe(w[15:8], 1'b0, 1'b0, 1'b0, 1'b0);
      owe(w[7:0], 1'b0, 1'b0, 1'b0, 1'b0);
    endfunction

    function void take_request(logic m, logic [PIXEL_W-1:0] px);
      logic is_final_px;
      logic is_burst;
      if (m == MODE_START) begin
        starts++;
        pixels_sent = '0;
        burst_pos = '0;
        frame_open = (pixel_total != '0);
        owe(CMD_COLUMN_ADDR, 1'b1, 1'b0, 1'b0, 1'b0);
        owe_word(col_start);
        owe_word(col_end);
        owe(CMD_ROW_ADDR, 1'b1, 1'b0, 1'b0, 1'b0);
        owe_word(row_start);
        owe_word(row_end);
        owe(CMD_MEMORY_WRITE, 1'b1, 1'b1, 1'b0, 1'b0);
      end else if (!frame_open) begin
        pixels_dropped++;
      end else begin
        pixels_taken++;
        pixels_sent = pixels_sent + 1'b1;
        burst_pos = burst_pos + 1'b1;
        // a lowered total closes the frame on the very next pixel
        is_final_px = (pixels_sent >= pixel_total);
        is_burst = (burst_pos >= BURST_PIXELS) || is_final_px;
        if (burst_pos >= BURST_PIXELS) burst_pos = '0;
        if (is_final_px) begin
          frame_open = 1'b0;
          frames_closed++;
        end
        owe(px[15:8], 1'b0, 1'b0, 1'b0, 1'b0);
        owe(px[7:0], 1'b0, 1'b1, is_burst, is_final_px);
      end
    endfunction

    function void compare(string field, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        faults++;
      end
    endfunction

    function void match_byte(panel_byte_t got);
      panel_byte_t want;
      if (bytes_due.size() == 0) begin
        $error("out_byte: expected none, got %0h", got.value);
        faults++;
      end else begin
        want = bytes_due.pop_front();
        bytes_checked++;
        compare("out_byte", want.value, got.value);
        compare("is_command", 8'(want.cmd), 8'(got.cmd));
        compare("last_of_run", 8'(want.last), 8'(got.last));
        compare("burst_end", 8'(want.burst), 8'(got.burst));
        compare("frame_end", 8'(want.frame), 8'(got.frame));
      end
    endfunction

    function int unsigned pending();
      return bytes_due.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic                  mode_i;
  logic [PIXEL_W-1:0]    pixel_value_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [7:0]            out_byte_o;
  logic                  is_command_o;
  logic                  last_of_run_o;
  logic                  burst_end_o;
  logic                  frame_end_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  panel_byte_tracker tracker = new();
  int unsigned       burst_left = 0;

  display_window_byte_writer_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .pixel_value_i (pixel_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .is_command_o  (is_command_o),
    .last_of_run_o (last_of_run_o),
    .burst_end_o   (burst_end_o),
    .frame_end_o   (frame_end_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      tracker.match_byte({out_byte_o, is_command_o, last_of_run_o, burst_end_o, frame_end_o});
    end
  end

  // Receiver: long open stretches, random stalls, fixed duty patterns and hard stalls.
  initial begin
    int unsigned style, span, on_len, off_len;
    out_ready_i = 1'b0;
    forever begin
      style = $urandom_range(0, 3);
      span = $urandom_range(10, 60);
      on_len = $urandom_range(1, 4);
      off_len = $urandom_range(1, 3);
      for (int unsigned k = 0; k < span; k++) begin
        @(negedge clk_i);
        case (style)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= ((k % (on_len + off_len)) < on_len);
          default: out_ready_i <= (k >= 12);
        endcase
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic push_request(input logic m, input logic [PIXEL_W-1:0] px);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    mode_i <= m;
    pixel_value_i <= px;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.take_request(m, px);
    @(negedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    tracker.set_register(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Hold the sender until every owed byte is out, then let a dropped pixel clear.
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (tracker.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [PIXEL_W-1:0] pick_pixel();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return PIXEL_W'($urandom());
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_coord();
    logic [7:0] junk;
    junk = 8'($urandom());
    case ($urandom_range(0, 4))
      0: return {junk, 16'h0000};
      1: return {junk, 16'hFFFF};
      default: return {junk, 16'($urandom())};
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_total();
    case ($urandom_range(0, 19))
      0, 1: return '0;
      2: return CFG_DATA_W'($urandom());
      3, 4, 5: return CFG_DATA_W'($urandom_range(46, 70));
      default: return CFG_DATA_W'($urandom_range(1, 45));
    endcase
  endfunction

  initial begin
    int unsigned n_px;
    logic        m;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    mode_i = MODE_START;
    pixel_value_i = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty window: pixels around a start with a zero total are dropped
    push_request(MODE_PIXEL, 16'hFFFF);
    push_request(MODE_START, '0);
    push_request(MODE_PIXEL, 16'h1234);
    drain();

    write_register(REG_COL_START, 24'h00FFFF);
    write_register(REG_COL_END, 24'hFF0000);
    write_register(REG_ROW_START, 24'hA51234);
    write_register(REG_ROW_END, 24'h00FFFF);
    write_register(REG_PIXEL_TOTAL, 24'd3);
    write_register(CFG_IDX_W'(5), 24'hFFFFFF);
    write_register(CFG_IDX_W'(6), 24'h000001);
    write_register(CFG_IDX_W'(7), 24'h800000);
    push_request(MODE_START, 16'hFFFF);
    push_request(MODE_PIXEL, 16'hFFFF);
    push_request(MODE_PIXEL, 16'h0000);
    push_request(MODE_PIXEL, 16'h8001);
    push_request(MODE_PIXEL, 16'h5AA5);
    drain();

    // single-pixel frame: burst and frame end on the same byte
    write_register(REG_PIXEL_TOTAL, 24'd1);
    push_request(MODE_START, '0);
    push_request(MODE_PIXEL, 16'h7FFE);
    drain();

    // abandon an endless frame, then change the window and lower the total mid-frame
    write_register(REG_PIXEL_TOTAL, 24'hFFFFFF);
    push_request(MODE_START, '0);
    push_request(MODE_PIXEL, 16'h00FF);
    push_request(MODE_PIXEL, 16'hFF00);
    push_request(MODE_START, '0);
    push_request(MODE_PIXEL, 16'h0F0F);
    drain();
    write_register(REG_COL_START, 24'h000000);
    write_register(REG_PIXEL_TOTAL, 24'd1);
    push_request(MODE_PIXEL, 16'hF0F0);
    push_request(MODE_PIXEL, 16'hAAAA);
    push_request(MODE_START, '0);
    drain();

    while (tracker.starts + tracker.pixels_taken < 500) begin
      if ($urandom_range(0, 1)) write_register(REG_COL_START, pick_coord());
      if ($urandom_range(0, 1)) write_register(REG_COL_END, pick_coord());
      if ($urandom_range(0, 1)) write_register(REG_ROW_START, pick_coord());
      if ($urandom_range(0, 1)) write_register(REG_ROW_END, pick_coord());
      if ($urandom_range(0, 9) == 0) write_register(CFG_IDX_W'($urandom_range(5, 7)), 24'($urandom()));
      write_register(REG_PIXEL_TOTAL, pick_total());

      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 2)) push_request(MODE_PIXEL, pick_pixel());
      end
      push_request(MODE_START, '0);
      n_px = (tracker.pixel_total > 80) ? $urandom_range(1, 30) : tracker.pixel_total;
      case ($urandom_range(0, 9))
        0: n_px = $urandom_range(0, n_px);
        1: n_px = n_px + $urandom_range(1, 3);
        default: ;
      endcase
      for (int unsigned k = 0; k < n_px; k++) begin
        // now and then pause mid-frame and move the total or the window
        if (k == n_px / 2 && $urandom_range(0, 7) == 0) begin
          drain();
          if ($urandom_range(0, 1))
            write_register(REG_PIXEL_TOTAL, CFG_DATA_W'($urandom_range(0, k + 4)));
          else write_register(REG_COL_START, pick_coord());
        end
        // a little noise: a stray start now and then
        m = ($urandom_range(0, 59) == 0) ? MODE_START : MODE_PIXEL;
        push_request(m, pick_pixel());
      end
      if ($urandom_range(0, 2) == 0) drain();
      else begin
        in_valid_i <= 1'b0;
        burst_left = 0;
        while (tracker.pending() != 0) @(negedge clk_i);
        repeat (4) @(negedge clk_i);
      end
    end

    drain();
    repeat (20) @(negedge clk_i);
    $display("Run covered %0d start requests and %0d pixels (%0d dropped outside a frame).",
             tracker.starts, tracker.pixels_taken, tracker.pixels_dropped);
    $display("%0d frames closed, %0d bytes compared, %0d mismatches.",
             tracker.frames_closed, tracker.bytes_checked, tracker.faults);
    if (tracker.faults == 0 && tracker.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/dwbw_pkg.sv
hw/rtl/dwbw_frame_ctrl.sv
hw/rtl/dwbw_byte_seq.sv
hw/rtl/display_window_byte_writer_unit.sv
test/display_window_byte_writer_unit_tb.sv
